@@ rtl/twrtc_pkg.sv @@
package twrtc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_OUT_LOW  = 3'd2,
    PH_OUT_HIGH = 3'd3,
    PH_IN_LOW   = 3'd4,
    PH_IN_HIGH  = 3'd5,
    PH_STOP     = 3'd6
  } phase_t;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

endpackage

@@ rtl/three_wire_rtc_serial_master_unit.sv @@
// Master for a three-wire real-time-clock bus (chip enable, serial clock and
// a bidirectional data line). Each item on the input channel is one bus timer
// tick. It carries a start request, the operation (0 write, 1 read), the
// command byte, the write data and the level of the data pin on that tick.
// The input channel takes one item per cycle whenever the result register is
// free or is being emptied in the same cycle.
// Each accepted item yields exactly one item on the output channel in the cycle
// after: pin levels (chip_enable, serial_clock, serial_data_out, data_drive),
// busy_res, the done_res pulse and read_data. Throughput is one item per cycle
// without stalls, set by the single result register between the two sides.
// When the receiver stalls, the result register holds its item and in_ready
// drops until that item is taken, so no item is lost or repeated.
// The configuration channel writes half_period_ticks, the number of ticks per
// serial clock half period; a value of zero acts as one. It is always ready.
// Synchronous reset returns the bus to idle, clears the shift registers and
// loads a half period of 50 ticks. No result is pending after reset.
module three_wire_rtc_serial_master_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_req,
  input  logic        operation,
  input  logic [7:0]  command_byte,
  input  logic [7:0]  write_data,
  input  logic        serial_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        chip_enable,
  output logic        serial_clock,
  output logic        serial_data_out,
  output logic        data_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import twrtc_pkg::*;

  logic [15:0] half_period_ticks;
  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [15:0] divider_count, divider_count_next;
  logic [7:0]  shift_out, shift_out_next;
  logic [7:0]  shift_in, shift_in_next;
  logic        is_read, is_read_next;
  logic [7:0]  pending_data, pending_data_next;
  logic        done_next;

  logic [15:0] half_period;
  logic [15:0] div_inc;
  logic [3:0]  bit_inc;
  logic        accept;

  logic ce_next, sclk_next, dout_next, drive_next;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign half_period = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign div_inc     = divider_count + 16'd1;
  assign bit_inc     = bit_count + 4'd1;

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    divider_count_next = divider_count;
    shift_out_next     = shift_out;
    shift_in_next      = shift_in;
    is_read_next       = is_read;
    pending_data_next  = pending_data;
    done_next          = 1'b0;
    if (phase == PH_IDLE) begin
      if (start_req) begin
        is_read_next       = operation;
        shift_out_next     = {command_byte[7:1], operation};
        pending_data_next  = write_data;
        bit_count_next     = 4'd0;
        divider_count_next = 16'd0;
        phase_next         = PH_START;
      end
    end else begin
      divider_count_next = div_inc;
      if (div_inc >= half_period) begin
        divider_count_next = 16'd0;
        case (phase)
          PH_START: begin
            phase_next = PH_OUT_LOW;
          end
          PH_OUT_LOW: begin
            phase_next = PH_OUT_HIGH;
          end
          PH_OUT_HIGH: begin
            shift_out_next = {1'b0, shift_out[7:1]};
            bit_count_next = bit_inc;
            if (bit_inc == BITS_PER_BYTE) begin
              if (is_read) begin
                bit_count_next = 4'd0;
                phase_next     = PH_IN_LOW;
              end else begin
                shift_out_next = pending_data;
                phase_next     = PH_OUT_LOW;
              end
            end else if (bit_inc == 4'd0) begin
              phase_next = PH_STOP;
            end else begin
              phase_next = PH_OUT_LOW;
            end
          end
          PH_IN_LOW: begin
            shift_in_next = {serial_data_in, shift_in[7:1]};
            phase_next    = PH_IN_HIGH;
          end
          PH_IN_HIGH: begin
            bit_count_next = bit_inc;
            phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_STOP : PH_IN_LOW;
          end
          PH_STOP: begin
            phase_next     = PH_IDLE;
            bit_count_next = 4'd0;
            done_next      = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    ce_next    = 1'b0;
    sclk_next  = 1'b0;
    dout_next  = 1'b0;
    drive_next = 1'b0;
    case (phase_next)
      PH_START, PH_OUT_LOW: begin
        ce_next    = 1'b1;
        drive_next = 1'b1;
        dout_next  = shift_out_next[0];
      end
      PH_OUT_HIGH: begin
        ce_next    = 1'b1;
        sclk_next  = 1'b1;
        drive_next = 1'b1;
        dout_next  = shift_out_next[0];
      end
      PH_IN_LOW, PH_STOP: begin
        ce_next = 1'b1;
      end
      PH_IN_HIGH: begin
        ce_next   = 1'b1;
        sclk_next = 1'b1;
      end
      default: begin
        ce_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      phase             <= PH_IDLE;
      bit_count         <= 4'd0;
      divider_count     <= 16'd0;
      shift_out         <= 8'd0;
      shift_in          <= 8'd0;
      is_read           <= 1'b0;
      pending_data      <= 8'd0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_period_ticks <= cfg_data;
      end
      if (accept) begin
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        divider_count <= divider_count_next;
        shift_out     <= shift_out_next;
        shift_in      <= shift_in_next;
        is_read       <= is_read_next;
        pending_data  <= pending_data_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chip_enable     <= ce_next;
      serial_clock    <= sclk_next;
      serial_data_out <= dout_next;
      data_drive      <= drive_next;
      busy_res        <= (phase_next != PH_IDLE);
      done_res        <= done_next;
      read_data       <= shift_in_next;
    end
  end

endmodule

@@ bench/three_wire_rtc_serial_master_unit_tb.sv @@
module three_wire_rtc_serial_master_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twrtc_pkg::*;

  typedef struct packed {
    logic       ce;
    logic       sclk;
    logic       dout;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
  } pin_sample_t;

  class rtc_bus_scoreboard;
    phase_t      phase;
    logic [3:0]  bit_cnt;
    logic [15:0] div_cnt;
    logic [15:0] half_period;
    logic [7:0]  tx_shift;
    logic [7:0]  rx_shift;
    logic [7:0]  tx_pending;
    logic        rd_mode;
    pin_sample_t expected_q[$];
    int          mismatches;

    function new();
      phase = PH_IDLE;
      bit_cnt = '0;
      div_cnt = '0;
      half_period = HALF_PERIOD_RESET;
      tx_shift = '0;
      rx_shift = '0;
      tx_pending = '0;
      rd_mode = 1'b0;
      mismatches = 0;
    endfunction

    function void set_half_period(logic [15:0] value);
      half_period = value;
    endfunction

    function bit bus_active();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_tick(logic start, logic op, logic [7:0] cmd, logic [7:0] wd,
                            logic din);
      pin_sample_t s;
      logic [15:0] hp;
      s = '0;
      hp = (half_period == 16'd0) ? 16'd1 : half_period;
      if (phase == PH_IDLE) begin
        if (start) begin
          rd_mode = op;
          tx_shift = {cmd[7:1], op};
          tx_pending = wd;
          bit_cnt = '0;
          div_cnt = '0;
          phase = PH_START;
        end
      end else begin
        div_cnt = div_cnt + 16'd1;
        if (div_cnt >= hp) begin
          div_cnt = '0;
          case (phase)
            PH_START: phase = PH_OUT_LOW;
            PH_OUT_LOW: phase = PH_OUT_HIGH;
            PH_OUT_HIGH: begin
              tx_shift = tx_shift >> 1;
              bit_cnt = bit_cnt + 4'd1;
              if (bit_cnt == BITS_PER_BYTE) begin
                if (rd_mode) begin
                  bit_cnt = '0;
                  phase = PH_IN_LOW;
                end else begin
                  tx_shift = tx_pending;
                  phase = PH_OUT_LOW;
                end
              end else if (bit_cnt == 4'd0) begin
                phase = PH_STOP;
              end else begin
                phase = PH_OUT_LOW;
              end
            end
            PH_IN_LOW: begin
              rx_shift = {din, rx_shift[7:1]};
              phase = PH_IN_HIGH;
            end
            PH_IN_HIGH: begin
              bit_cnt = bit_cnt + 4'd1;
              phase = (bit_cnt >= BITS_PER_BYTE) ? PH_STOP : PH_IN_LOW;
            end
            PH_STOP: begin
              phase = PH_IDLE;
              bit_cnt = '0;
              s.done = 1'b1;
            end
            default: phase = PH_IDLE;
          endcase
        end
      end
      case (phase)
        PH_START, PH_OUT_LOW: begin
          s.ce = 1'b1;
          s.drive = 1'b1;
          s.dout = tx_shift[0];
        end
        PH_OUT_HIGH: begin
          s.ce = 1'b1;
          s.sclk = 1'b1;
          s.drive = 1'b1;
          s.dout = tx_shift[0];
        end
        PH_IN_LOW, PH_STOP: s.ce = 1'b1;
        PH_IN_HIGH: begin
          s.ce = 1'b1;
          s.sclk = 1'b1;
        end
        default: ;
      endcase
      s.busy = (phase != PH_IDLE);
      s.rdata = rx_shift;
      expected_q.push_back(s);
    endfunction

    function void compare_field(string label, int want, int got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %0h, got %0h", label, want, got);
      end
    endfunction

    function void check_sample(pin_sample_t got);
      pin_sample_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item arrived with none expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("chip_enable", int'(want.ce), int'(got.ce));
      compare_field("serial_clock", int'(want.sclk), int'(got.sclk));
      compare_field("serial_data_out", int'(want.dout), int'(got.dout));
      compare_field("data_drive", int'(want.drive), int'(got.drive));
      compare_field("busy_res", int'(want.busy), int'(got.busy));
      compare_field("done_res", int'(want.done), int'(got.done));
      compare_field("read_data", int'(want.rdata), int'(got.rdata));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        start_req = 1'b0;
  logic        operation = 1'b0;
  logic [7:0]  command_byte = '0;
  logic [7:0]  write_data = '0;
  logic        serial_data_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        chip_enable;
  logic        serial_clock;
  logic        serial_data_out;
  logic        data_drive;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  rtc_bus_scoreboard sb;

  three_wire_rtc_serial_master_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_req(start_req),
    .operation(operation),
    .command_byte(command_byte),
    .write_data(write_data),
    .serial_data_in(serial_data_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .chip_enable(chip_enable),
    .serial_clock(serial_clock),
    .serial_data_out(serial_data_out),
    .data_drive(data_drive),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_sample(pin_sample_t'({chip_enable, serial_clock, serial_data_out,
                                     data_drive, busy_res, done_res, read_data}));
  end

  task automatic send_tick(input logic s, input logic op, input logic [7:0] cmd,
                           input logic [7:0] wd, input logic din);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_req <= s;
    operation <= op;
    command_byte <= cmd;
    write_data <= wd;
    serial_data_in <= din;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(s, op, cmd, wd, din);
    @(negedge clk);
  endtask

  task automatic random_tick(input logic s);
    send_tick(s, 1'($urandom_range(1)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic run_transaction(input logic op, input logic [7:0] cmd,
                                 input logic [7:0] wd, input int din_mode,
                                 input logic hold_start);
    logic din;
    din = (din_mode == 2) ? 1'($urandom_range(1)) : 1'(din_mode);
    send_tick(1'b1, op, cmd, wd, din);
    while (sb.bus_active()) begin
      din = (din_mode == 2) ? 1'($urandom_range(1)) : 1'(din_mode);
      send_tick(hold_start, 1'($urandom_range(1)), 8'($urandom_range(255)),
                8'($urandom_range(255)), din);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_half_period(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #10ms;
    $display("three_wire_rtc_serial_master_unit_tb: done, errors");
    $finish;
  end

  initial begin
    logic [15:0] seg_half[6];
    seg_half = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd5, 16'd1};
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset half period first, then the shortest one with the pin extremes.
    send_tick(1'b1, 1'b1, 8'hFE, 8'h00, 1'b1);
    repeat (80) random_tick(1'b0);
    wait_drained();
    write_half_period(16'd0);
    while (sb.bus_active()) random_tick(1'b0);
    run_transaction(1'b0, 8'hFF, 8'h00, 2, 1'b0);
    run_transaction(1'b0, 8'h00, 8'hFF, 2, 1'b0);
    run_transaction(1'b1, 8'h01, 8'h5A, 0, 1'b0);
    run_transaction(1'b1, 8'hFE, 8'hA5, 1, 1'b0);
    run_transaction(1'b1, 8'h80, 8'h00, 2, 1'b1);
    run_transaction(1'b0, 8'h7F, 8'h81, 2, 1'b1);
    repeat (3) random_tick(1'b0);
    wait_drained();
    write_half_period(16'd1);
    run_transaction(1'b0, 8'hC3, 8'h3C, 2, 1'b1);
    run_transaction(1'b1, 8'h3C, 8'hC3, 2, 1'b0);

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg / 2 == 0) ? 20 : (seg / 2 == 1) ? 65 : 0;
      recv_idle_pct = (seg / 2 == 0) ? 65 : (seg / 2 == 1) ? 20 : 0;
      wait_drained();
      write_half_period(seg_half[seg]);
      repeat (80) random_tick($urandom_range(3) == 0);
      while (sb.bus_active()) random_tick(1'b0);
    end

    // The longest half period leaves the bus parked in its start phase.
    send_idle_pct = 20;
    recv_idle_pct = 65;
    wait_drained();
    write_half_period(16'hFFFF);
    repeat (120) random_tick($urandom_range(3) == 0);
    wait_drained();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("three_wire_rtc_serial_master_unit_tb: done, clean");
    else
      $display("three_wire_rtc_serial_master_unit_tb: done, errors");
    $finish;
  end
endmodule
